// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int LIM_W          = 11;
  localparam int SHIFT_W        = 3;
  localparam logic [7:0] FULL_BYTE = 8'hff;
  localparam logic [LIM_W-1:0] RST_BLOCK_LIMIT = 11'd1024;
  localparam logic [SHIFT_W-1:0] RST_SECTOR_SHIFT = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_START   = 2'd0,
    REG_SECTOR_SHIFT = 2'd1,
    REG_BLOCK_LIMIT  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    RES_FULL,
    RES_ALLOC,
    RES_FREE
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_FREE_CALC,
    ST_FREE_RD,
    ST_FREE_WR
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] freed_sector;
    logic        run_last;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] block_sector;
    logic        done_res;
  } out_item_t;

  typedef struct packed {
    logic      accept;
    logic      clr_en;
    logic      scan_en;
    logic      alloc_wr;
    logic      free_calc;
    logic      free_rd;
    logic      free_wr;
    logic      finish;
    res_kind_t res_kind;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic count_zero;
    logic hit;
    logic exhausted;
  } stat_t;

endpackage

// ===== rtl/bitmap_block_allocator_unit.sv =====
`timescale 1ns / 1ps

// first-fit bitmap block allocator. after reset the block is busy while the bitmap is cleared
// one byte a cycle; configuration writes are taken meanwhile. an item is taken when start is
// high and busy is low; its result appears on out_data with out_valid for one cycle and
// cannot be held off. an allocate scans bytes from 0 up to the first byte with a clear bit,
// or to the last byte below block_limit, through the single bitmap read port reading one
// byte a cycle; an allocate with a zero free count answers in the next cycle; a free
// computes the offset, reads the byte and writes it back. one item is in flight at a time.
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          start,
  input  bba_pkg::in_item_t             in_data,
  output logic                          busy,
  output logic                          out_valid,
  output bba_pkg::out_item_t            out_data
);

  bba_pkg::ctrl_t ctrl;
  bba_pkg::stat_t stat;

  bba_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .stat   (stat),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_cmd,
  input  bba_pkg::stat_t stat,
  output logic           busy,
  output bba_pkg::ctrl_t ctrl
);

  bba_pkg::state_t state_r;
  bba_pkg::state_t state_nxt;
  logic            accept;

  assign busy   = (state_r != bba_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bba_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == bba_pkg::CMD_FREE) state_nxt = bba_pkg::ST_FREE_CALC;
          else if (!stat.count_zero) state_nxt = bba_pkg::ST_SCAN;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (stat.hit) state_nxt = bba_pkg::ST_ALLOC_WR;
        else if (stat.exhausted) state_nxt = bba_pkg::ST_IDLE;
      end
      bba_pkg::ST_ALLOC_WR:  state_nxt = bba_pkg::ST_IDLE;
      bba_pkg::ST_FREE_CALC: state_nxt = bba_pkg::ST_FREE_RD;
      bba_pkg::ST_FREE_RD:   state_nxt = bba_pkg::ST_FREE_WR;
      bba_pkg::ST_FREE_WR:   state_nxt = bba_pkg::ST_IDLE;
      default:               state_nxt = bba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.res_kind = bba_pkg::RES_FULL;
    unique case (state_r)
      bba_pkg::ST_CLEAR: ctrl.clr_en = 1'b1;
      bba_pkg::ST_IDLE: begin
        ctrl.accept = accept;
        // allocate with no free block answers at once
        if (accept && in_cmd == bba_pkg::CMD_ALLOC && stat.count_zero) begin
          ctrl.finish = 1'b1;
        end
      end
      bba_pkg::ST_SCAN: begin
        ctrl.scan_en = !stat.hit && !stat.exhausted;
        if (!stat.hit && stat.exhausted) ctrl.finish = 1'b1;
      end
      bba_pkg::ST_ALLOC_WR: begin
        ctrl.alloc_wr = 1'b1;
        ctrl.finish   = 1'b1;
        ctrl.res_kind = bba_pkg::RES_ALLOC;
      end
      bba_pkg::ST_FREE_CALC: ctrl.free_calc = 1'b1;
      bba_pkg::ST_FREE_RD:   ctrl.free_rd = 1'b1;
      bba_pkg::ST_FREE_WR: begin
        ctrl.free_wr  = 1'b1;
        ctrl.finish   = 1'b1;
        ctrl.res_kind = bba_pkg::RES_FREE;
      end
      default: ctrl = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_no_finish_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> state_r != bba_pkg::ST_CLEAR)
    else $error("finish during clearing pass");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept |=> $past(state_r) == bba_pkg::ST_IDLE)
    else $error("accept outside idle");
  a_alloc_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::ST_ALLOC_WR |-> $past(state_r) == bba_pkg::ST_SCAN)
    else $error("alloc write without scan");
`endif

endmodule

// ===== rtl/bba_datapath.sv =====
`timescale 1ns / 1ps

module bba_datapath #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_wdata,
  input  bba_pkg::in_item_t               in_data,
  input  bba_pkg::ctrl_t                  ctrl,
  output bba_pkg::stat_t                  stat,
  output logic                            out_valid,
  output bba_pkg::out_item_t              out_data
);

  localparam int MAP_BYTES = MAX_BLOCKS / 8;
  localparam int IDX_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BLK_W     = IDX_W + 3;

  function automatic logic [bba_pkg::LIM_W-1:0] eff_lim(input logic [bba_pkg::LIM_W-1:0] raw);
    logic [bba_pkg::LIM_W-1:0] v;
    v = raw & ~bba_pkg::LIM_W'(7);
    if (v < bba_pkg::LIM_W'(8)) v = bba_pkg::LIM_W'(8);
    if (32'(v) > 32'(MAX_BLOCKS)) v = bba_pkg::LIM_W'(MAX_BLOCKS) & ~bba_pkg::LIM_W'(7);
    return v;
  endfunction

  logic [7:0] mem [MAP_BYTES];

  logic [31:0]                  ds_r;
  logic [bba_pkg::SHIFT_W-1:0]  shift_r;
  logic [bba_pkg::LIM_W-1:0]    lim_r;
  logic [bba_pkg::LIM_W-1:0]    fc_r;
  logic [31:0]                  sector_r;
  logic                         last_r;
  logic [IDX_W-1:0]             clr_addr_r;
  logic [IDX_W-1:0]             scan_addr_r;
  logic [IDX_W-1:0]             chk_addr_r;
  logic                         rd_vld_r;
  logic [7:0]                   rdata_r;
  logic [BLK_W-1:0]             blk_r;
  logic                         in_rng_r;
  logic                         out_valid_r;
  bba_pkg::out_item_t           out_data_r;

  logic [IDX_W-1:0]             last_idx;
  logic [IDX_W-1:0]             rd_addr;
  logic                         rd_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [7:0]                   wr_data;
  logic                         wr_en;
  logic [2:0]                   first_clr;
  logic                         found;
  logic [BLK_W-1:0]             alloc_blk;
  logic [31:0]                  alloc_sec;
  logic [31:0]                  free_off;
  logic [31:0]                  free_blk;
  logic                         free_ok;
  logic [7:0]                   free_mask;

  assign last_idx = IDX_W'(lim_r[bba_pkg::LIM_W-1:3] - 8'd1);

  assign stat.clr_last   = (clr_addr_r == IDX_W'(MAP_BYTES - 1));
  assign stat.count_zero = (fc_r == '0);
  assign stat.hit        = rd_vld_r && (rdata_r != bba_pkg::FULL_BYTE);
  assign stat.exhausted  = rd_vld_r && (rdata_r == bba_pkg::FULL_BYTE) &&
                           (chk_addr_r == last_idx);

  // first clear bit, msb is the lowest block of the byte
  always_comb begin
    first_clr = 3'd0;
    found     = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && !rdata_r[i]) begin
        first_clr = 3'(7 - i);
        found     = 1'b1;
      end
    end
  end

  assign alloc_blk = {chk_addr_r, first_clr};
  assign alloc_sec = ds_r + (32'(alloc_blk) << shift_r);

  assign free_off  = sector_r - ds_r;
  assign free_blk  = free_off >> shift_r;
  assign free_ok   = (sector_r >= ds_r) && (free_blk < 32'(lim_r));
  assign free_mask = 8'h80 >> blk_r[2:0];

  always_comb begin
    rd_addr = ctrl.free_rd ? blk_r[BLK_W-1:3] : scan_addr_r;
    rd_en   = (ctrl.scan_en || ctrl.free_rd) && (32'(rd_addr) < 32'(MAP_BYTES));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = 8'h00;
    if (ctrl.clr_en) begin
      wr_en = 1'b1;
    end else if (ctrl.alloc_wr) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr_r;
      wr_data = rdata_r | (8'h80 >> first_clr);
    end else if (ctrl.free_wr) begin
      wr_en   = in_rng_r;
      wr_addr = blk_r[BLK_W-1:3];
      wr_data = rdata_r & ~free_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r    <= '0;
      shift_r <= bba_pkg::RST_SECTOR_SHIFT;
      lim_r   <= eff_lim(bba_pkg::RST_BLOCK_LIMIT);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bba_pkg::REG_DATA_START:   ds_r <= cfg_wdata;
        bba_pkg::REG_SECTOR_SHIFT: shift_r <= cfg_wdata[bba_pkg::SHIFT_W-1:0];
        bba_pkg::REG_BLOCK_LIMIT:  lim_r <= eff_lim(cfg_wdata[bba_pkg::LIM_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= eff_lim(bba_pkg::RST_BLOCK_LIMIT);
    end else if (cfg_we && cfg_idx == bba_pkg::REG_BLOCK_LIMIT) begin
      fc_r <= eff_lim(cfg_wdata[bba_pkg::LIM_W-1:0]);
    end else if (ctrl.alloc_wr) begin
      fc_r <= fc_r - bba_pkg::LIM_W'(1);
    end else if (ctrl.free_wr && in_rng_r && fc_r < lim_r) begin
      fc_r <= fc_r + bba_pkg::LIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (ctrl.clr_en) clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (ctrl.accept) rd_vld_r <= 1'b0;
      else if (ctrl.scan_en) rd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      sector_r    <= in_data.freed_sector;
      last_r      <= in_data.run_last;
      scan_addr_r <= '0;
    end else if (ctrl.scan_en) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
      chk_addr_r  <= scan_addr_r;
    end
    if (ctrl.free_calc) begin
      blk_r    <= BLK_W'(free_blk);
      in_rng_r <= free_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      unique case (ctrl.res_kind)
        bba_pkg::RES_ALLOC: out_data_r <= '{status: 1'b0, block_sector: alloc_sec,
                                            done_res: 1'b0};
        bba_pkg::RES_FREE:  out_data_r <= '{status: 1'b0, block_sector: 32'd0,
                                            done_res: last_r};
        default:            out_data_r <= '{status: 1'b1, block_sector: 32'd0,
                                            done_res: 1'b0};
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= lim_r)
    else $error("free count above block limit");
  a_alloc_has_clear_bit: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.alloc_wr |-> rdata_r != bba_pkg::FULL_BYTE && fc_r != '0)
    else $error("alloc write on full byte or zero count");
  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |=> out_valid_r)
    else $error("finish without result strobe");
`endif

endmodule

// ===== tb/bitmap_block_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_tb;

  localparam int MAP_BYTES  = bba_pkg::DEF_MAX_BLOCKS / 8;
  localparam int IDLE_LIMIT = 2000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [bba_pkg::CFG_IDX_W-1:0] cfg_idx = bba_pkg::REG_DATA_START;
  logic [bba_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          start = 1'b0;
  bba_pkg::in_item_t             in_data = '0;
  logic                          busy;
  logic                          out_valid;
  bba_pkg::out_item_t            out_data;

  // shadow copy of the allocator state
  logic [31:0]               data_start_reg = '0;
  logic [2:0]                shift_reg = bba_pkg::RST_SECTOR_SHIFT;
  logic [bba_pkg::LIM_W-1:0] blk_limit_reg = bba_pkg::RST_BLOCK_LIMIT;
  logic [7:0]                used_map [MAP_BYTES];
  int                        blocks_free = bba_pkg::DEF_MAX_BLOCKS;

  bba_pkg::out_item_t pending_answers [$];
  bba_pkg::out_item_t want;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;

  bitmap_block_allocator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int limit_eff(logic [bba_pkg::LIM_W-1:0] raw);
    int v;
    v = int'(raw & 11'h7f8);
    if (v < 8) v = 8;
    if (v > bba_pkg::DEF_MAX_BLOCKS) v = bba_pkg::DEF_MAX_BLOCKS;
    return v;
  endfunction

  function automatic bba_pkg::out_item_t predict_allocator_answer(bba_pkg::in_item_t it);
    bba_pkg::out_item_t res;
    int                 lim;
    int                 j;
    int                 byte_i;
    int                 bit_i;
    logic [31:0]        off;
    res = '0;
    lim = limit_eff(blk_limit_reg);
    if (it.cmd == bba_pkg::CMD_ALLOC) begin
      if (blocks_free == 0) begin
        res.status = 1'b1;
        return res;
      end
      byte_i = -1;
      for (j = 0; j < lim / 8; j++)
        if (byte_i < 0 && used_map[j] != bba_pkg::FULL_BYTE) byte_i = j;
      // count can be stale after a limit write, map decides
      if (byte_i < 0) begin
        res.status = 1'b1;
        return res;
      end
      bit_i = 0;
      while (used_map[byte_i][7 - bit_i]) bit_i++;
      used_map[byte_i][7 - bit_i] = 1'b1;
      blocks_free--;
      off = 32'(byte_i * 8 + bit_i) << shift_reg;
      res.block_sector = data_start_reg + off;
    end else begin
      res.done_res = it.run_last;
      if (it.freed_sector >= data_start_reg) begin
        off = (it.freed_sector - data_start_reg) >> shift_reg;
        if (off < lim) begin
          used_map[off >> 3][7 - off[2:0]] = 1'b0;
          if (blocks_free < lim) blocks_free++;
        end
      end
    end
    return res;
  endfunction

  // a sector inside some used block below the limit (its start or a random offset in it), random when none is used
  function automatic logic [31:0] sector_of_used_block();
    int          lim;
    int          first;
    int          i;
    int          b;
    logic [31:0] unaligned;
    lim = limit_eff(blk_limit_reg);
    first = $urandom_range(lim - 1);
    unaligned = ($urandom_range(3) == 0) ? ($urandom & ((32'd1 << shift_reg) - 1)) : 32'd0;
    for (i = 0; i < lim; i++) begin
      b = (first + i) % lim;
      if (used_map[b / 8][7 - b % 8])
        return data_start_reg + (32'(b) << shift_reg) + unaligned;
    end
    return $urandom;
  endfunction

  function automatic bba_pkg::in_item_t make_item(logic cmd, logic [31:0] sector, logic last);
    bba_pkg::in_item_t it;
    it.cmd = cmd;
    it.freed_sector = sector;
    it.run_last = last;
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, exp_val);
    mismatch_count++;
  endtask

  // one request transfer, predicted at the edge that takes it
  task automatic issue_request(bba_pkg::in_item_t it);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      if ($urandom_range(19) == 0) burst_left = $urandom_range(10, 40);
      gap = $urandom_range(15);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(predict_allocator_answer(it));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic apply_config(logic [31:0] ds, logic [2:0] sh,
                              logic [bba_pkg::LIM_W-1:0] lim);
    cfg_we <= 1'b1;
    cfg_idx <= bba_pkg::REG_DATA_START;
    cfg_wdata <= ds;
    @(posedge clk);
    data_start_reg = ds;
    cfg_idx <= bba_pkg::REG_SECTOR_SHIFT;
    cfg_wdata <= {29'd0, sh};
    @(posedge clk);
    shift_reg = sh;
    cfg_idx <= bba_pkg::REG_BLOCK_LIMIT;
    cfg_wdata <= {21'd0, lim};
    @(posedge clk);
    blk_limit_reg = lim;
    blocks_free = limit_eff(lim);
    cfg_we <= 1'b0;
  endtask

  task automatic test_first_allocations();
    issue_request(make_item(bba_pkg::CMD_ALLOC, 32'hffff_ffff, 1'b1));
    issue_request(make_item(bba_pkg::CMD_ALLOC, 32'h0, 1'b0));
    issue_request(make_item(bba_pkg::CMD_ALLOC, $urandom, 1'b0));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'd2, 1'b1));
    issue_request(make_item(bba_pkg::CMD_ALLOC, 32'd0, 1'b1));
    // odd sector of a block that was never taken
    issue_request(make_item(bba_pkg::CMD_FREE, 32'd7, 1'b0));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'hffff_ffff, 1'b0));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'd0, 1'b1));
  endtask

  task automatic test_full_map();
    int i;
    drain_results();
    apply_config(32'h100, 3'd0, 11'd12);
    issue_request(make_item(bba_pkg::CMD_FREE, 32'h101, 1'b0));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'h102, 1'b1));
    for (i = 0; i < 9; i++)
      issue_request(make_item(bba_pkg::CMD_ALLOC, $urandom, i[0]));
    drain_results();
    // count restored while every bit is still set
    apply_config(32'h100, 3'd0, 11'd8);
    issue_request(make_item(bba_pkg::CMD_ALLOC, 32'h0, 1'b0));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'h0ff, 1'b1));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'h108, 1'b0));
  endtask

  task automatic test_sector_wrap();
    drain_results();
    apply_config(32'hffff_fff0, 3'd7, 11'd2047);
    issue_request(make_item(bba_pkg::CMD_ALLOC, 32'h0, 1'b0));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'h0000_03f0, 1'b1));
    issue_request(make_item(bba_pkg::CMD_FREE, 32'hffff_fff0, 1'b0));
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    int          alloc_pct;
    logic [31:0] sector;
    for (phase = 0; phase < 10; phase++) begin
      drain_results();
      case (phase)
        0: apply_config(32'd0, 3'd0, 11'd0);
        1: apply_config(32'hffff_ffff, 3'd7, 11'd2047);
        2: apply_config($urandom_range(4096), 3'd1, 11'd1024);
        default: apply_config(($urandom_range(3) == 0) ? $urandom : $urandom_range(65535),
                              3'($urandom_range(7)),
                              ($urandom_range(3) == 0) ?
                                  bba_pkg::LIM_W'($urandom_range(2047)) :
                                  bba_pkg::LIM_W'($urandom_range(8, 64)));
      endcase
      case ($urandom_range(3))
        0: alloc_pct = 25;
        1: alloc_pct = 50;
        2: alloc_pct = 75;
        default: alloc_pct = 90;
      endcase
      for (n = 0; n < 170; n++) begin
        if ($urandom_range(99) < alloc_pct) begin
          issue_request(make_item(bba_pkg::CMD_ALLOC, $urandom, 1'($urandom_range(1))));
        end else begin
          if ($urandom_range(9) < 7) begin
            sector = sector_of_used_block();
          end else begin
            case ($urandom_range(2))
              0: sector = $urandom;
              1: sector = data_start_reg - 32'($urandom_range(1, 16));
              default: sector = data_start_reg +
                  (32'(limit_eff(blk_limit_reg) + $urandom_range(64)) << shift_reg);
            endcase
          end
          issue_request(make_item(bba_pkg::CMD_FREE, sector, 1'($urandom_range(1))));
        end
        if ($urandom_range(99) == 0) drain_results();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", out_data.block_sector, 32'd0);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.block_sector !== want.block_sector)
          report_mismatch("block_sector", out_data.block_sector, want.block_sector);
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", 32'(out_data.done_res), 32'(want.done_res));
      end
    end
  end

  // no transfer of any kind for too long means the block is stuck
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bitmap_block_allocator_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (used_map[i]) used_map[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_first_allocations();
    test_full_map();
    test_sector_wrap();
    test_random_traffic();
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("bitmap_block_allocator_unit verification clean");
    end else begin
      $display("bitmap_block_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/bitmap_block_allocator_unit.sv
tb/bitmap_block_allocator_unit_tb.sv
